// ----- design/pfs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the PER-from-SNR interpolator.
// Used by the top level and by its checker; depends on nothing.
package pfs_pkg;

    localparam int SNR_W = 16;
    localparam int PER_W = 16;
    localparam int EPS_W = 8;
    localparam int MCS_W = 3;
    localparam int OP_W  = 2;

    localparam logic [OP_W-1:0]  OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0]  OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0]  OP_CLEAR = 2'd2;

    localparam logic [PER_W-1:0] PER_ONE   = 16'hFFFF;
    localparam logic [EPS_W-1:0] EPS_RESET = 8'd3;

    typedef enum logic [8:0]
    {
        ST_IDLE  = 9'b000000001,
        ST_LIST  = 9'b000000010,
        ST_FIRST = 9'b000000100,
        ST_LAST  = 9'b000001000,
        ST_WALK  = 9'b000010000,
        ST_MUL1  = 9'b000100000,
        ST_MUL2  = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } state_t;

endpackage

// ----- design/pfs_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the breakpoint store of the interpolator.
module pfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/per_from_snr_interpolator.sv -----
`timescale 1ns / 1ps
// Top level of the PER-from-SNR interpolator: sequencer, count registers, output register.
// Depends on pfs_pkg and pfs_ram.

// Load and clear beats leave the sequencer idle, so the block stays ready for the next beat.
// A query beat holds the input side low while a small sequencer walks the lists in index
// order through the one read port of the breakpoint RAM. Empty lists are skipped; a list
// with points may go through two end checks, the walk, two passes through a single 16x16
// multiplier and a 16-step restoring divider. A stalled output holds the sequencer in its
// emit state.
// The breakpoint RAM needs no clearing after reset, since only stored entries are used.
module per_from_snr_interpolator
    import pfs_pkg::*;
#(
    parameter int MCS_COUNT      = 8,
    parameter int POINTS_PER_MCS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] mcs, [18:3] snr_db, [34:19] per_value, [39:35] zero.
    input  logic [39:0] s_axis_tdata,
    // [1:0] op.
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] result_mcs, [18:3] result_per, [23:19] zero.
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    localparam int DEPTH = MCS_COUNT * POINTS_PER_MCS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW    = (MCS_COUNT > 1) ? $clog2(MCS_COUNT) : 1;
    localparam int IW    = $clog2(POINTS_PER_MCS);
    localparam int CW    = $clog2(POINTS_PER_MCS + 1);

    state_t                   state_reg, state_next;
    logic [EPS_W-1:0]         eps_reg, eps_next;
    logic [CW-1:0]            cnt_reg [MCS_COUNT];
    logic [CW-1:0]            cnt_next [MCS_COUNT];
    logic [MW-1:0]            m_reg, m_next;
    logic [IW-1:0]            i_reg, i_next;
    logic [3:0]               div_cnt_reg, div_cnt_next;
    logic                     out_valid_reg, out_valid_next;

    logic signed [SNR_W-1:0]  s_reg, s_next;
    logic signed [SNR_W-1:0]  prev_snr_reg, prev_snr_next;
    logic [PER_W-1:0]         prev_per_reg, prev_per_next;
    logic [PER_W-1:0]         cur_per_reg, cur_per_next;
    logic [15:0]              above_reg, above_next;
    logic [15:0]              below_reg, below_next;
    logic [15:0]              den_reg, den_next;
    logic [31:0]              num_reg, num_next;
    logic [15:0]              rem_reg, rem_next;
    logic [PER_W-1:0]         res_reg, res_next;
    logic [MCS_W-1:0]         out_mcs_reg, out_mcs_next;
    logic [PER_W-1:0]         out_per_reg, out_per_next;
    logic                     out_last_reg, out_last_next;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [AW-1:0]            ram_raddr;
    logic [31:0]              ram_rdata;

    logic [MCS_W-1:0]         in_mcs;
    logic signed [SNR_W-1:0]  in_snr;
    logic [PER_W-1:0]         in_per;
    logic [MW-1:0]            ld_m;
    logic                     in_accept;
    logic [CW-1:0]            n_cur;
    logic                     m_at_end;
    logic                     last_flag;
    logic [15:0]              mul_a, mul_b;
    logic [31:0]              prod;

    assign in_mcs    = s_axis_tdata[2:0];
    assign in_snr    = s_axis_tdata[18:3];
    assign in_per    = s_axis_tdata[34:19];
    assign ld_m      = MW'(in_mcs);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign n_cur     = cnt_reg[m_reg];
    assign m_at_end  = (32'(m_reg) == MCS_COUNT - 1);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_per_reg, out_mcs_reg};
    assign m_axis_tlast  = out_last_reg;

    assign mul_a = (state_reg == ST_MUL1) ? above_reg : below_reg;
    assign mul_b = (state_reg == ST_MUL1) ? prev_per_reg : cur_per_reg;
    assign prod  = mul_a * mul_b;

    assign ram_we    = in_accept && (s_axis_tuser == OP_LOAD) && (32'(in_mcs) < MCS_COUNT)
                       && (32'(cnt_reg[ld_m]) < POINTS_PER_MCS);
    assign ram_waddr = AW'(32'(ld_m) * POINTS_PER_MCS + 32'(cnt_reg[ld_m]));

    always_comb
    begin
        last_flag = 1'b1;
        for (int k = 0; k < MCS_COUNT; k++)
        begin
            if ((32'(m_reg) < k) && (cnt_reg[k] != '0))
            begin
                last_flag = 1'b0;
            end
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_FIRST: ram_raddr = AW'(32'(m_reg) * POINTS_PER_MCS + 32'(n_cur) - 1);
            ST_WALK:  ram_raddr = AW'(32'(m_reg) * POINTS_PER_MCS + 32'(i_reg) + 1);
            default:  ram_raddr = AW'(32'(m_reg) * POINTS_PER_MCS);
        endcase
    end

    pfs_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_points (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_per, in_snr}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic signed [SNR_W-1:0] rd_snr;
        logic [PER_W-1:0]        rd_per;
        logic signed [16:0]      diff;
        logic [16:0]             abs_diff;
        logic signed [16:0]      below;
        logic signed [17:0]      eps18;
        logic [31:0]             sum;
        logic [16:0]             shifted;
        logic                    qbit;

        rd_snr   = ram_rdata[15:0];
        rd_per   = ram_rdata[31:16];
        diff     = 17'(rd_snr) - 17'(s_reg);
        abs_diff = (diff < 0) ? 17'(-diff) : 17'(diff);
        below    = 17'(s_reg) - 17'(prev_snr_reg);
        eps18    = {10'b0, eps_reg};
        sum      = num_reg + prod;
        shifted  = {rem_reg, num_reg[15]};
        qbit     = (shifted >= {1'b0, den_reg});

        state_next     = state_reg;
        eps_next       = cfg_wr_en ? cfg_wr_data : eps_reg;
        cnt_next       = cnt_reg;
        m_next         = m_reg;
        i_next         = i_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        s_next         = s_reg;
        prev_snr_next  = prev_snr_reg;
        prev_per_next  = prev_per_reg;
        cur_per_next   = cur_per_reg;
        above_next     = above_reg;
        below_next     = below_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        out_mcs_next   = out_mcs_reg;
        out_per_next   = out_per_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (s_axis_tuser)
                        OP_LOAD:
                        begin
                            if (ram_we)
                            begin
                                cnt_next[ld_m] = cnt_reg[ld_m] + 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            for (int k = 0; k < MCS_COUNT; k++)
                            begin
                                cnt_next[k] = '0;
                            end
                        end
                        OP_QUERY:
                        begin
                            s_next     = in_snr;
                            m_next     = '0;
                            state_next = ST_LIST;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LIST:
            begin
                if (n_cur == '0)
                begin
                    if (m_at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        m_next = m_reg + 1'b1;
                    end
                end
                else if (n_cur == CW'(1))
                begin
                    res_next   = PER_ONE;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (18'(rd_snr) + eps18 >= 18'(s_reg))
                begin
                    res_next   = rd_per;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                if (18'(rd_snr) - eps18 <= 18'(s_reg))
                begin
                    res_next   = rd_per;
                    state_next = ST_EMIT;
                end
                else
                begin
                    i_next     = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (abs_diff <= {9'b0, eps_reg})
                begin
                    res_next   = rd_per;
                    state_next = ST_EMIT;
                end
                else if ((diff > 0) && (i_reg != '0))
                begin
                    if (below < 0)
                    begin
                        res_next   = PER_ONE;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        above_next   = diff[15:0];
                        below_next   = below[15:0];
                        den_next     = diff[15:0] + below[15:0];
                        cur_per_next = rd_per;
                        state_next   = ST_MUL1;
                    end
                end
                else
                begin
                    prev_snr_next = rd_snr;
                    prev_per_next = rd_per;
                    if (CW'(i_reg) + 1'b1 == n_cur)
                    begin
                        res_next   = PER_ONE;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            ST_MUL1:
            begin
                num_next   = prod;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                // The weighted sum stays below den * 2^16, so the upper half is a
                // valid starting remainder and the quotient fits in 16 bits.
                num_next     = sum;
                rem_next     = sum[31:16];
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next        = qbit ? 16'(shifted - {1'b0, den_reg}) : shifted[15:0];
                num_next[15:0]  = {num_reg[14:0], qbit};
                div_cnt_next    = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 4'd15)
                begin
                    res_next   = {num_reg[14:0], qbit};
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_mcs_next   = MCS_W'(m_reg);
                    out_per_next   = res_reg;
                    out_last_next  = last_flag;
                    if (m_at_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        m_next     = m_reg + 1'b1;
                        state_next = ST_LIST;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            eps_reg       <= EPS_RESET;
            m_reg         <= '0;
            i_reg         <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MCS_COUNT; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            eps_reg       <= eps_next;
            m_reg         <= m_next;
            i_reg         <= i_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        prev_snr_reg <= prev_snr_next;
        prev_per_reg <= prev_per_next;
        cur_per_reg  <= cur_per_next;
        above_reg    <= above_next;
        below_reg    <= below_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        res_reg      <= res_next;
        out_mcs_reg  <= out_mcs_next;
        out_per_reg  <= out_per_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ----- design/pfs_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the PER-from-SNR interpolator, bound to the top level.
// Depends on pfs_pkg and per_from_snr_interpolator.
module pfs_checker
    import pfs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // Loads, clears and unused codes finish in the cycle they are taken.
    a_quick_ops: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_QUERY) |=> s_axis_tready)
        else $error("input side not ready after a load or clear beat");

    // A query occupies the sequencer.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_QUERY) |=> !s_axis_tready)
        else $error("input side ready right after a query beat");

    // While a query still owes results, no new beat is taken.
    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("input side ready in the middle of a result run");

endmodule

bind per_from_snr_interpolator pfs_checker u_pfs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
